@@ design/b2a_pkg.sv @@
package b2a_pkg;

  localparam int unsigned KindW   = 3;
  localparam int unsigned ValueW  = 32;
  localparam int unsigned DigitsW = 8;
  localparam int unsigned CharW   = 8;
  localparam int unsigned CountW  = 5;

  localparam logic [KindW-1:0] KIND_UDEC = 3'd0;
  localparam logic [KindW-1:0] KIND_SDEC = 3'd1;
  localparam logic [KindW-1:0] KIND_HEX  = 3'd2;
  localparam logic [KindW-1:0] KIND_Q16  = 3'd3;
  localparam logic [KindW-1:0] KIND_FIX  = 3'd4;

  localparam logic [CountW-1:0] MAX_CHARS_RST = 5'd31;

  localparam logic [CharW-1:0] CHAR_ZERO     = 8'h30;
  localparam logic [CharW-1:0] CHAR_HEX_BASE = 8'h37;
  localparam logic [CharW-1:0] CHAR_MINUS    = 8'h2D;
  localparam logic [CharW-1:0] CHAR_POINT    = 8'h2E;
  localparam logic [CharW-1:0] CHAR_NONE     = 8'h00;

  function automatic logic [CharW-1:0] dec_char(input logic [3:0] nib);
    return CHAR_ZERO + {4'b0000, nib};
  endfunction

  function automatic logic [CharW-1:0] hex_char(input logic [3:0] nib);
    logic [CharW-1:0] c;
    if (nib < 4'd10) begin
      c = CHAR_ZERO + {4'b0000, nib};
    end else begin
      c = CHAR_HEX_BASE + {4'b0000, nib};
    end
    return c;
  endfunction

endpackage

@@ design/b2a_if.sv @@
interface b2a_in_if;
  import b2a_pkg::*;

  logic               valid;
  logic               ready;
  logic [KindW-1:0]   kind;
  logic [ValueW-1:0]  value;
  logic [DigitsW-1:0] digits;

  modport source (output valid, kind, value, digits, input ready);
  modport sink (input valid, kind, value, digits, output ready);
endinterface

interface b2a_out_if;
  import b2a_pkg::*;

  logic              valid;
  logic              ready;
  logic [CharW-1:0]  character;
  logic              last;
  logic              empty_res;
  logic              truncated;
  logic [CountW-1:0] written_count;

  modport source (output valid, character, last, empty_res, truncated, written_count,
                  input ready);
  modport sink (input valid, character, last, empty_res, truncated, written_count,
                output ready);
endinterface

interface b2a_cfg_if;
  import b2a_pkg::*;

  logic              valid;
  logic              ready;
  logic [CountW-1:0] data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

@@ design/binary_to_ascii_number_converter.sv @@
// Channel   Dir  Word carried
// --------  ---  ----------------------------------------------------------
// cfg_i     in   max_chars (always ready)
// in_i      in   kind, value, digits (ready only between items)
// out_o     out  character, last, empty_res, truncated, written_count
//
// An item is taken in the idle state, then goes through a bit-serial shift-add-3
// conversion (of the integer half only for Q16.16, skipped for hex), a sizing
// step and the emission of one output word per kept character.
// Reset brings max_chars to 31 and empties the output register.
// A stalled output holds the current word and pauses character generation.
module binary_to_ascii_number_converter (
  input logic     clk_i,
  input logic     rst_ni,
  b2a_cfg_if.sink cfg_i,
  b2a_in_if.sink  in_i,
  b2a_out_if.source out_o
);
  import b2a_pkg::*;

  localparam int unsigned BcdDigits = 10;
  localparam int unsigned BcdW      = 4 * BcdDigits;
  localparam int unsigned HexDigits = ValueW / 4;
  localparam int unsigned FracW     = ValueW / 2;

  typedef enum logic [2:0] {
    StIdle,
    StConv,
    StSize,
    StSign,
    StInt,
    StPoint,
    StFrac
  } state_e;

  state_e             state_q;
  logic [CountW-1:0]  max_chars_q;
  logic [CountW-1:0]  kept_q;
  logic [CountW-1:0]  cnt_q;
  logic               trunc_q;
  logic [3:0]         idx_q;
  logic [3:0]         rem_q;
  logic [4:0]         bitcnt_q;
  logic               ovalid_q;
  logic [CharW-1:0]   ochar_q;
  logic               olast_q;
  logic               oempty_q;
  logic               otrunc_q;
  logic [CountW-1:0]  ocount_q;

  logic [KindW-1:0]   kind_q;
  logic [3:0]         dg_q;
  logic               neg_q;
  logic [ValueW-1:0]  sh_q;
  logic [BcdW-1:0]    bcd_q;
  logic [FracW-1:0]   frac_q;

  logic               in_accept;
  logic               in_neg;
  logic [ValueW-1:0]  in_mag;
  logic [3:0]         dg_clamp;
  logic [BcdW-1:0]    bcd_adj;
  logic [3:0]         nd;
  logic [3:0]         nh;
  logic [3:0]         hex_n;
  logic [3:0]         ndq;
  logic [4:0]         frac_len;
  logic [4:0]         len_c;
  logic [3:0]         int_n;
  logic [3:0]         idx0;
  logic [CountW-1:0]  kept_c;
  logic [3:0]         bcd_dig;
  logic [3:0]         hex_nib;
  logic [FracW+3:0]   frac_x10;
  logic               emitting;
  logic               out_free;
  logic               push;
  logic               is_last;
  logic [CharW-1:0]   char_c;
  logic               last_c;
  logic               empty_c;
  logic               trunc_c;
  logic [CountW-1:0]  count_c;

  assign in_accept   = (state_q == StIdle) && in_i.valid;
  assign in_i.ready  = (state_q == StIdle);
  assign cfg_i.ready = 1'b1;

  assign in_neg = in_i.value[ValueW-1] &&
                  ((in_i.kind == KIND_SDEC) || (in_i.kind == KIND_Q16) ||
                   (in_i.kind == KIND_FIX));
  assign in_mag = in_neg ? (~in_i.value + 32'd1) : in_i.value;

  always_comb begin
    case (in_i.kind)
      KIND_HEX: dg_clamp = (in_i.digits > 8'd8) ? 4'd8 : in_i.digits[3:0];
      KIND_Q16: dg_clamp = (in_i.digits > 8'd6) ? 4'd6 : in_i.digits[3:0];
      KIND_FIX: dg_clamp = (in_i.digits > 8'd9) ? 4'd9 : in_i.digits[3:0];
      default:  dg_clamp = 4'd0;
    endcase
  end

  always_comb begin
    for (int i = 0; i < BcdDigits; i++) begin
      bcd_adj[4*i +: 4] = (bcd_q[4*i +: 4] >= 4'd5) ? (bcd_q[4*i +: 4] + 4'd3)
                                                     : bcd_q[4*i +: 4];
    end
  end

  always_comb begin
    nd      = 4'd1;
    nh      = 4'd0;
    bcd_dig = 4'd0;
    hex_nib = 4'd0;
    for (int i = 1; i < BcdDigits; i++) begin
      if (bcd_q[4*i +: 4] != 4'd0) begin
        nd = 4'(i + 1);
      end
    end
    for (int i = 0; i < HexDigits; i++) begin
      if (sh_q[4*i +: 4] != 4'd0) begin
        nh = 4'(i + 1);
      end
    end
    for (int i = 0; i < BcdDigits; i++) begin
      if (idx_q == 4'(i)) begin
        bcd_dig = bcd_q[4*i +: 4];
      end
    end
    for (int i = 0; i < HexDigits; i++) begin
      if (idx_q == 4'(i)) begin
        hex_nib = sh_q[4*i +: 4];
      end
    end
  end

  always_comb begin
    hex_n    = (nh > dg_q) ? nh : dg_q;
    if (hex_n == 4'd0) begin
      hex_n = 4'd1;
    end
    ndq      = (nd > dg_q) ? (nd - dg_q) : 4'd1;
    frac_len = (dg_q != 4'd0) ? ({1'b0, dg_q} + 5'd1) : 5'd0;
    case (kind_q)
      KIND_UDEC: begin
        len_c = {1'b0, nd};
        int_n = nd;
        idx0  = nd - 4'd1;
      end
      KIND_SDEC: begin
        len_c = {4'b0000, neg_q} + {1'b0, nd};
        int_n = nd;
        idx0  = nd - 4'd1;
      end
      KIND_HEX: begin
        len_c = {1'b0, hex_n};
        int_n = hex_n;
        idx0  = hex_n - 4'd1;
      end
      KIND_Q16: begin
        len_c = {4'b0000, neg_q} + {1'b0, nd} + frac_len;
        int_n = nd;
        idx0  = nd - 4'd1;
      end
      KIND_FIX: begin
        len_c = {4'b0000, neg_q} + {1'b0, ndq} + frac_len;
        int_n = ndq;
        idx0  = dg_q + ndq - 4'd1;
      end
      default: begin
        len_c = 5'd0;
        int_n = 4'd1;
        idx0  = 4'd0;
      end
    endcase
    kept_c = (len_c < max_chars_q) ? len_c : max_chars_q;
  end

  assign frac_x10 = {1'b0, frac_q, 3'b000} + {3'b000, frac_q, 1'b0};

  assign emitting = (state_q == StSign) || (state_q == StInt) ||
                    (state_q == StPoint) || (state_q == StFrac);
  assign out_free = !ovalid_q || out_o.ready;
  assign push     = out_free && (emitting || ((state_q == StSize) && (kept_c == '0)));
  assign is_last  = (cnt_q == (kept_q - 5'd1));

  always_comb begin
    last_c  = is_last;
    empty_c = 1'b0;
    trunc_c = is_last && trunc_q;
    count_c = is_last ? kept_q : '0;
    case (state_q)
      StSign:  char_c = CHAR_MINUS;
      StInt:   char_c = (kind_q == KIND_HEX) ? hex_char(hex_nib) : dec_char(bcd_dig);
      StPoint: char_c = CHAR_POINT;
      StFrac:  char_c = (kind_q == KIND_Q16) ? dec_char(frac_x10[FracW+3:FracW])
                                              : dec_char(bcd_dig);
      default: begin
        char_c  = CHAR_NONE;
        last_c  = 1'b1;
        empty_c = 1'b1;
        trunc_c = (len_c > kept_c);
        count_c = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      max_chars_q <= MAX_CHARS_RST;
      kept_q      <= '0;
      cnt_q       <= '0;
      trunc_q     <= 1'b0;
      idx_q       <= '0;
      rem_q       <= '0;
      bitcnt_q    <= '0;
      ovalid_q    <= 1'b0;
      ochar_q     <= '0;
      olast_q     <= 1'b0;
      oempty_q    <= 1'b0;
      otrunc_q    <= 1'b0;
      ocount_q    <= '0;
    end else begin
      if (cfg_i.valid) begin
        max_chars_q <= cfg_i.data;
      end
      if (push) begin
        ovalid_q <= 1'b1;
        ochar_q  <= char_c;
        olast_q  <= last_c;
        oempty_q <= empty_c;
        otrunc_q <= trunc_c;
        ocount_q <= count_c;
      end else if (out_o.ready) begin
        ovalid_q <= 1'b0;
      end
      case (state_q)
        StIdle: begin
          if (in_i.valid) begin
            bitcnt_q <= (in_i.kind == KIND_Q16) ? 5'd15 : 5'd31;
            if ((in_i.kind == KIND_UDEC) || (in_i.kind == KIND_SDEC) ||
                (in_i.kind == KIND_Q16) || (in_i.kind == KIND_FIX)) begin
              state_q <= StConv;
            end else begin
              state_q <= StSize;
            end
          end
        end
        StConv: begin
          bitcnt_q <= bitcnt_q - 5'd1;
          if (bitcnt_q == 5'd0) begin
            state_q <= StSize;
          end
        end
        StSize: begin
          kept_q  <= kept_c;
          trunc_q <= (len_c > kept_c);
          cnt_q   <= '0;
          idx_q   <= idx0;
          rem_q   <= int_n;
          if (kept_c == '0) begin
            if (out_free) begin
              state_q <= StIdle;
            end
          end else begin
            state_q <= neg_q ? StSign : StInt;
          end
        end
        StSign: begin
          if (push) begin
            cnt_q   <= cnt_q + 5'd1;
            state_q <= is_last ? StIdle : StInt;
          end
        end
        StInt: begin
          if (push) begin
            cnt_q <= cnt_q + 5'd1;
            idx_q <= idx_q - 4'd1;
            rem_q <= rem_q - 4'd1;
            if (is_last) begin
              state_q <= StIdle;
            end else if (rem_q == 4'd1) begin
              state_q <= StPoint;
            end
          end
        end
        StPoint: begin
          if (push) begin
            cnt_q   <= cnt_q + 5'd1;
            state_q <= is_last ? StIdle : StFrac;
          end
        end
        StFrac: begin
          if (push) begin
            cnt_q <= cnt_q + 5'd1;
            idx_q <= idx_q - 4'd1;
            if (is_last) begin
              state_q <= StIdle;
            end
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      kind_q <= in_i.kind;
      dg_q   <= dg_clamp;
      neg_q  <= in_neg;
      sh_q   <= (in_i.kind == KIND_Q16) ? {in_mag[ValueW-1:FracW], {FracW{1'b0}}} : in_mag;
      frac_q <= in_mag[FracW-1:0];
      bcd_q  <= '0;
    end else if (state_q == StConv) begin
      bcd_q <= {bcd_adj[BcdW-2:0], sh_q[ValueW-1]};
      sh_q  <= {sh_q[ValueW-2:0], 1'b0};
    end else if ((state_q == StFrac) && push && (kind_q == KIND_Q16)) begin
      frac_q <= frac_x10[FracW-1:0];
    end
  end

  assign out_o.valid         = ovalid_q;
  assign out_o.character     = ochar_q;
  assign out_o.last          = olast_q;
  assign out_o.empty_res     = oempty_q;
  assign out_o.truncated     = otrunc_q;
  assign out_o.written_count = ocount_q;

`ifndef SYNTHESIS
  a_partial_word_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ovalid_q && !olast_q) |-> (state_q != StIdle))
    else $error("non-final character waits while the converter is idle");

  a_summary_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ovalid_q && !olast_q) |-> ((ocount_q == '0) && !otrunc_q))
    else $error("count or truncation shown before the final character");

  a_empty_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ovalid_q && oempty_q) |-> (olast_q && (ocount_q == '0)))
    else $error("empty marker is not a final word with zero count");

  a_count_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emitting |-> (cnt_q < kept_q))
    else $error("character counter ran past the kept length");
`endif

endmodule
